### rtl/cdo_pkg.sv
// Shared types, constants and calendar helpers for the date offset block.
// Depends on nothing; used by calendar_date_offset.
package cdo_pkg;

  // Largest year the block will hold
  localparam logic [13:0] MAX_YEAR = 14'd9999;

  localparam int unsigned MONTHS        = 12;
  localparam int unsigned DAYS_COMMON   = 365;
  localparam int unsigned DAYS_LEAP     = 366;
  localparam int unsigned CYCLE_YEARS   = 400;
  localparam int unsigned CENTURY_YEARS = 100;

  // Month lengths of a common year, January first
  localparam logic [4:0] MONTH_LEN [MONTHS] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Command codes
  localparam logic CMD_SET     = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_DATE = 2'd1;
  localparam logic [1:0] STATUS_RANGE    = 2'd2;

  // Input beat
  typedef struct packed {
    logic               cmd;
    logic [13:0]        set_year;
    logic [3:0]         set_month;
    logic [4:0]         set_day;
    logic signed [15:0] day_offset;
  } req_t;

  // Result beat
  typedef struct packed {
    logic [13:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [1:0]  status;
  } res_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DOY,
    ST_BACK,
    ST_FWD,
    ST_MON,
    ST_MOD,
    ST_CHK,
    ST_FINISH
  } cdo_state_t;

  // Leap test from the year's low two bits and its remainder modulo 400
  function automatic logic is_leap(input logic [1:0] yr_lo, input logic [8:0] r400);
    logic century;
    century = (r400 == 9'(CENTURY_YEARS)) || (r400 == 9'(2 * CENTURY_YEARS)) ||
              (r400 == 9'(3 * CENTURY_YEARS));
    return (yr_lo == 2'd0) && !century;
  endfunction

  function automatic logic [8:0] year_len(input logic leap);
    return leap ? 9'(DAYS_LEAP) : 9'(DAYS_COMMON);
  endfunction

  // Days in a month; zero for a month code outside 1..12
  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    logic [3:0] idx;
    idx = month - 4'd1;
    len = 5'd0;
    if (month != 4'd0 && month <= 4'(MONTHS)) begin
      len = MONTH_LEN[idx];
      if (month == 4'd2 && leap) begin
        len = len + 5'd1;
      end
    end
    return len;
  endfunction

endpackage

### rtl/calendar_date_offset.sv
// Calendar date register: set with validation, advance by a signed day offset.
// Depends on cdo_pkg (types, constants, month and leap helpers).
//
//  channel | signals                       | beat
//  --------+-------------------------------+----------------------------------
//  request | req_valid, req_ready, req     | one set or advance command
//  result  | res_valid, res_ready, res     | stored date and status per command
//
// One command at a time; a single 17-bit add/compare unit is stepped by the sequencer.
// Advance: a month walk to the day of year, a year walk back or forward, then a month
//   walk within the result year; the year walk through the shared adder dominates.
// Set: the modulo-400 walk dominates, followed by the day check against the month length.
// Reset gives 0000-01-01. A stalled result holds the block in its final state.

module calendar_date_offset (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  cdo_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output cdo_pkg::res_t res
);

  // Stored date, plus the year modulo 400 kept alongside for the leap rule
  logic [13:0] cur_year, cur_year_next;
  logic [3:0]  cur_month, cur_month_next;
  logic [4:0]  cur_day, cur_day_next;
  logic [8:0]  cur_r400, cur_r400_next;

  // Working registers
  cdo_pkg::cdo_state_t state, state_next;
  logic [13:0]        wy, wy_next;
  logic [8:0]         wr400, wr400_next;
  logic [3:0]         wm, wm_next;
  logic [4:0]         wd, wd_next;
  logic signed [16:0] days, days_next;
  logic [1:0]         st, st_next;
  logic               res_valid_next;
  cdo_pkg::res_t      res_next;

  // Shared arithmetic unit
  logic signed [16:0] opb;
  logic signed [16:0] sum;
  logic               sum_neg;

  // Leap status of the working year and of the year before it
  logic [13:0] py;
  logic [8:0]  pr400;
  logic        leap_w;
  logic        leap_p;

  assign py     = wy - 14'd1;
  assign pr400  = (wr400 == 9'd0) ? 9'(cdo_pkg::CYCLE_YEARS - 1) : wr400 - 9'd1;
  assign leap_w = cdo_pkg::is_leap(wy[1:0], wr400);
  assign leap_p = cdo_pkg::is_leap(py[1:0], pr400);

  // Operand selection for the adder
  always_comb begin
    opb = '0;
    case (state)
      cdo_pkg::ST_DOY: begin
        if (wm < cur_month) begin
          opb = $signed({12'b0, cdo_pkg::month_days(wm, leap_w)});
        end else begin
          opb = $signed({12'b0, 5'(cur_day - 5'd1)});
        end
      end
      cdo_pkg::ST_BACK: opb = $signed({8'b0, cdo_pkg::year_len(leap_p)});
      cdo_pkg::ST_FWD:  opb = -$signed({8'b0, cdo_pkg::year_len(leap_w)});
      cdo_pkg::ST_MON:  opb = -$signed({12'b0, cdo_pkg::month_days(wm, leap_w)});
      cdo_pkg::ST_MOD:  opb = -$signed(17'(cdo_pkg::CYCLE_YEARS));
      default:          opb = '0;
    endcase
  end

  assign sum     = days + opb;
  assign sum_neg = sum[16];
  assign req_ready = (state == cdo_pkg::ST_IDLE);

  // Sequencer: next state and working register updates
  always_comb begin
    state_next     = state;
    wy_next        = wy;
    wr400_next     = wr400;
    wm_next        = wm;
    wd_next        = wd;
    days_next      = days;
    st_next        = st;
    cur_year_next  = cur_year;
    cur_month_next = cur_month;
    cur_day_next   = cur_day;
    cur_r400_next  = cur_r400;
    res_next       = res;
    res_valid_next = res_valid && !res_ready;

    unique case (state)
      cdo_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (req.cmd == cdo_pkg::CMD_ADVANCE) begin
            wy_next    = cur_year;
            wr400_next = cur_r400;
            wm_next    = 4'd1;
            days_next  = {req.day_offset[15], req.day_offset};
            state_next = cdo_pkg::ST_DOY;
          end else begin
            wy_next   = req.set_year;
            wm_next   = req.set_month;
            wd_next   = req.set_day;
            days_next = $signed({3'b0, req.set_year});
            if (req.set_year > cdo_pkg::MAX_YEAR || req.set_month == 4'd0 ||
                req.set_month > 4'(cdo_pkg::MONTHS) || req.set_day == 5'd0) begin
              st_next    = cdo_pkg::STATUS_BAD_DATE;
              state_next = cdo_pkg::ST_FINISH;
            end else begin
              state_next = cdo_pkg::ST_MOD;
            end
          end
        end
      end

      // Day of year of the stored date, added onto the offset
      cdo_pkg::ST_DOY: begin
        days_next = sum;
        if (wm < cur_month) begin
          wm_next = wm + 4'd1;
        end else begin
          state_next = cdo_pkg::ST_BACK;
        end
      end

      // Walk back whole years while the day count is negative
      cdo_pkg::ST_BACK: begin
        if (!days[16]) begin
          state_next = cdo_pkg::ST_FWD;
        end else if (wy == 14'd0) begin
          st_next    = cdo_pkg::STATUS_RANGE;
          state_next = cdo_pkg::ST_FINISH;
        end else begin
          wy_next    = py;
          wr400_next = pr400;
          days_next  = sum;
        end
      end

      // Walk forward whole years while the count reaches past this year
      cdo_pkg::ST_FWD: begin
        if (sum_neg) begin
          wm_next    = 4'd1;
          state_next = cdo_pkg::ST_MON;
        end else if (wy == cdo_pkg::MAX_YEAR) begin
          st_next    = cdo_pkg::STATUS_RANGE;
          state_next = cdo_pkg::ST_FINISH;
        end else begin
          wy_next    = wy + 14'd1;
          wr400_next = (wr400 == 9'(cdo_pkg::CYCLE_YEARS - 1)) ? 9'd0 : wr400 + 9'd1;
          days_next  = sum;
        end
      end

      // Walk months within the year
      cdo_pkg::ST_MON: begin
        if (wm < 4'(cdo_pkg::MONTHS) && !sum_neg) begin
          days_next = sum;
          wm_next   = wm + 4'd1;
        end else begin
          wd_next    = days[4:0] + 5'd1;
          st_next    = cdo_pkg::STATUS_OK;
          state_next = cdo_pkg::ST_FINISH;
        end
      end

      // Year modulo 400 for a set command
      cdo_pkg::ST_MOD: begin
        if (!sum_neg) begin
          days_next = sum;
        end else begin
          wr400_next = days[8:0];
          state_next = cdo_pkg::ST_CHK;
        end
      end

      // Day against the month length
      cdo_pkg::ST_CHK: begin
        if (wd > cdo_pkg::month_days(wm, leap_w)) begin
          st_next = cdo_pkg::STATUS_BAD_DATE;
        end else begin
          st_next = cdo_pkg::STATUS_OK;
        end
        state_next = cdo_pkg::ST_FINISH;
      end

      // Commit and hand the result to the output register
      cdo_pkg::ST_FINISH: begin
        if (!res_valid || res_ready) begin
          res_valid_next = 1'b1;
          res_next.status = st;
          if (st == cdo_pkg::STATUS_OK) begin
            cur_year_next      = wy;
            cur_month_next     = wm;
            cur_day_next       = wd;
            cur_r400_next      = wr400;
            res_next.out_year  = wy;
            res_next.out_month = wm;
            res_next.out_day   = wd;
          end else begin
            res_next.out_year  = cur_year;
            res_next.out_month = cur_month;
            res_next.out_day   = cur_day;
          end
          state_next = cdo_pkg::ST_IDLE;
        end
      end

      default: state_next = cdo_pkg::ST_IDLE;
    endcase
  end

  // Control state and stored date
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cdo_pkg::ST_IDLE;
      res_valid <= 1'b0;
      cur_year  <= 14'd0;
      cur_month <= 4'd1;
      cur_day   <= 5'd1;
      cur_r400  <= 9'd0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
      cur_year  <= cur_year_next;
      cur_month <= cur_month_next;
      cur_day   <= cur_day_next;
      cur_r400  <= cur_r400_next;
    end
  end

  // Working datapath and result register
  always_ff @(posedge clk) begin
    wy    <= wy_next;
    wr400 <= wr400_next;
    wm    <= wm_next;
    wd    <= wd_next;
    days  <= days_next;
    st    <= st_next;
    res   <= res_next;
  end

`ifndef NO_ASSERTIONS
  // Stored date always holds a real month and a nonzero day
  a_cur_date_sane: assert property (@(posedge clk) disable iff (rst)
    cur_month != 4'd0 && cur_month <= 4'(cdo_pkg::MONTHS) && cur_day != 5'd0)
    else $error("stored date out of range");

  // Year remainder tracks the year
  a_r400_tracks: assert property (@(posedge clk) disable iff (rst)
    cur_r400 < 9'(cdo_pkg::CYCLE_YEARS) && cur_r400[1:0] == cur_year[1:0] &&
    cur_year <= cdo_pkg::MAX_YEAR)
    else $error("year remainder out of step with year");

  // An accepted command starts the sequencer
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state != cdo_pkg::ST_IDLE)
    else $error("accepted command did not start");

  // The date only changes as a result is issued
  a_commit_only_at_finish: assert property (@(posedge clk) disable iff (rst)
    state != cdo_pkg::ST_FINISH |=>
      $stable(cur_year) && $stable(cur_month) && $stable(cur_day))
    else $error("date changed outside result issue");
`endif

endmodule

### test/calendar_date_offset_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for calendar_date_offset: set and advance beats are checked against a
// calendar model of its own that walks the Gregorian calendar. Depends on cdo_pkg and the RTL.
module calendar_date_offset_tb;

  // Watchdog limit, with margin over the slowest run
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int DRAIN_CYCLES  = 160;
  localparam int RANDOM_BEATS  = 1775;
  localparam int MAX_PRINTED   = 40;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic res_ready = 1'b0;
  cdo_pkg::req_t req = '0;
  logic req_ready;
  logic res_valid;
  cdo_pkg::res_t res;

  calendar_date_offset dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Model copy of the stored date
  int   date_year  = 0;
  int   date_month = 1;
  int   date_day   = 1;
  cdo_pkg::res_t pending_dates[$];
  cdo_pkg::res_t want;

  int cycle_count  = 0;
  int mismatches   = 0;
  int results_seen = 0;
  int beats_sent   = 0;
  int burst_left   = 0;
  int n_set        = 0;
  int n_bad_set    = 0;
  int n_advance    = 0;
  int n_out_range  = 0;
  int stall_mode   = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_dates.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side stalls: one of four randomly chosen ready patterns
  always @(posedge clk) begin
    if (cycle_count % 256 == 0) begin
      stall_mode = $urandom_range(0, 3);
    end
    case (stall_mode)
      0:       res_ready <= 1'b1;
      1:       res_ready <= ($urandom_range(0, 1) == 1);
      2:       res_ready <= ($urandom_range(0, 3) == 0);
      default: res_ready <= ((cycle_count % 16) >= 7);
    endcase
  end

  function automatic bit leap_year(input int y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int year_days(input int y);
    return leap_year(y) ? 366 : 365;
  endfunction

  // Zero for a month code outside 1..12
  function automatic int month_length(input int y, input int m);
    int len;
    len = 0;
    if (m >= 1 && m <= 12) begin
      len = int'(cdo_pkg::MONTH_LEN[m - 1]);
      if (m == 2 && leap_year(y)) len = 29;
    end
    return len;
  endfunction

  // Apply one beat to the model date and return the result it should give
  function automatic cdo_pkg::res_t next_date(input cdo_pkg::req_t beat);
    cdo_pkg::res_t r;
    logic [1:0]    st;
    int            days;
    int            y;
    int            m;
    st = cdo_pkg::STATUS_OK;
    if (beat.cmd == cdo_pkg::CMD_SET) begin
      n_set++;
      if (beat.set_year > cdo_pkg::MAX_YEAR || beat.set_day == 0 ||
          int'(beat.set_day) > month_length(beat.set_year, beat.set_month)) begin
        st = cdo_pkg::STATUS_BAD_DATE;
        n_bad_set++;
      end else begin
        date_year  = beat.set_year;
        date_month = beat.set_month;
        date_day   = beat.set_day;
      end
    end else begin
      n_advance++;
      // day index within the year, then add the offset
      days = date_day - 1;
      for (m = 1; m < date_month; m++) days += month_length(date_year, m);
      days += int'($signed(beat.day_offset));
      y = date_year;
      while (st == cdo_pkg::STATUS_OK && days < 0) begin
        y--;
        if (y < 0) st = cdo_pkg::STATUS_RANGE;
        else days += year_days(y);
      end
      while (st == cdo_pkg::STATUS_OK && days >= year_days(y)) begin
        days -= year_days(y);
        y++;
        if (y > int'(cdo_pkg::MAX_YEAR)) st = cdo_pkg::STATUS_RANGE;
      end
      if (st == cdo_pkg::STATUS_OK) begin
        m = 1;
        while (m < 12 && days >= month_length(y, m)) begin
          days -= month_length(y, m);
          m++;
        end
        date_year  = y;
        date_month = m;
        date_day   = days + 1;
      end else begin
        n_out_range++;
      end
    end
    r.out_year  = 14'(date_year);
    r.out_month = 4'(date_month);
    r.out_day   = 5'(date_day);
    r.status    = st;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // Predict on each accepted request, check each accepted result against the oldest
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) pending_dates.push_back(next_date(req));
      if (res_valid && res_ready) begin
        results_seen++;
        if (pending_dates.size() == 0) begin
          report_mismatch("result beat with nothing outstanding");
        end else begin
          want = pending_dates.pop_front();
          if (res.out_year !== want.out_year)
            report_mismatch($sformatf("year %0d, want %0d", res.out_year, want.out_year));
          if (res.out_month !== want.out_month)
            report_mismatch($sformatf("month %0d, want %0d", res.out_month, want.out_month));
          if (res.out_day !== want.out_day)
            report_mismatch($sformatf("day %0d, want %0d", res.out_day, want.out_day));
          if (res.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", res.status, want.status));
        end
      end
    end
  end

  // Send one request beat; bursts of random length separated by random gaps
  task automatic send_beat(input cdo_pkg::req_t beat);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    req       <= beat;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    beats_sent++;
  endtask

  // Offset field is noise on a set
  task automatic send_set(input int y, input int m, input int d);
    cdo_pkg::req_t beat;
    beat.cmd        = cdo_pkg::CMD_SET;
    beat.set_year   = 14'(y);
    beat.set_month  = 4'(m);
    beat.set_day    = 5'(d);
    beat.day_offset = 16'($urandom());
    send_beat(beat);
  endtask

  // Set fields are noise on an advance
  task automatic send_advance(input int off);
    cdo_pkg::req_t beat;
    beat.cmd        = cdo_pkg::CMD_ADVANCE;
    beat.set_year   = 14'($urandom());
    beat.set_month  = 4'($urandom());
    beat.set_day    = 5'($urandom());
    beat.day_offset = 16'(off);
    send_beat(beat);
  endtask

  function automatic int pick_offset();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return int'($urandom_range(0, 800)) - 400;
    if (sel < 7) return int'($urandom_range(0, 10000)) - 5000;
    if (sel < 9) return int'($signed(16'($urandom())));
    case ($urandom_range(0, 4))
      0:       return -32768;
      1:       return 32767;
      2:       return -1;
      3:       return 1;
      default: return 0;
    endcase
  endfunction

  // Validation of set beats: range, month codes, day limits and the leap rule
  task automatic test_set_checks();
    send_set(0, 1, 1);
    send_set(9999, 12, 31);
    send_set(16383, 1, 1);
    send_set(10000, 1, 1);
    send_set(2023, 0, 10);
    send_set(2023, 13, 10);
    send_set(2023, 15, 31);
    send_set(2023, 5, 0);
    send_set(2023, 4, 31);
    send_set(2000, 2, 29);
    send_set(1900, 2, 29);
    send_set(2024, 2, 29);
    send_set(2023, 2, 29);
    send_set(0, 2, 29);
    send_set(8191, 1, 31);
  endtask

  // Advances across leap days, the widest offsets and both ends of the year range
  task automatic test_advance_edges();
    send_set(2000, 3, 1);
    send_advance(-1);
    send_advance(0);
    send_advance(32767);
    send_advance(-32768);
    send_set(0, 1, 1);
    send_advance(-1);
    send_advance(32767);
    send_set(9999, 12, 31);
    send_advance(1);
    send_advance(-32768);
    send_set(1899, 12, 31);
    send_advance(60);
  endtask

  // Mostly a valid set followed by a run of advances; some rejected sets and raw noise
  task automatic test_random_walk();
    cdo_pkg::req_t beat;
    int   y;
    int   m;
    int   d;
    int   runs;
    while (beats_sent < RANDOM_BEATS + 28) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          beat = cdo_pkg::req_t'(40'({$urandom(), $urandom()}));
          send_beat(beat);
        end
        2, 3: begin
          m = $urandom_range(1, 12);
          case ($urandom_range(0, 3))
            0:       send_set($urandom_range(10000, 16383), m, 1);
            1:       send_set($urandom_range(0, 9999), $urandom_range(13, 16) & 15, 1);
            2:       send_set($urandom_range(0, 9999), m, 0);
            default: begin
              y = $urandom_range(0, 9999);
              m = 2 * $urandom_range(1, 5);
              if (m == 8 || m == 10) m = 11;
              send_set(y, m, $urandom_range(month_length(y, m) + 1, 31));
            end
          endcase
        end
        default: begin
          case ($urandom_range(0, 9))
            0:       y = $urandom_range(0, 100);
            1:       y = $urandom_range(9900, 9999);
            default: y = $urandom_range(0, 9999);
          endcase
          m = $urandom_range(1, 12);
          d = $urandom_range(1, month_length(y, m));
          send_set(y, m, d);
          runs = $urandom_range(1, 8);
          repeat (runs) send_advance(pick_offset());
        end
      endcase
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_set_checks();
    test_advance_edges();
    test_random_walk();
    req_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_dates.size() != 0) report_mismatch("results still outstanding at the end");
    $display("covered %0d set beats (%0d rejected), %0d advance beats (%0d out of range)",
             n_set, n_bad_set, n_advance, n_out_range);
    $display("%0d results checked in %0d cycles, %0d mismatches",
             results_seen, cycle_count, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
